### rtl/fcp_pkg.sv
package fcp_pkg;

    typedef enum logic [4:0] {
        CMD_UNKNOWN,
        CMD_C,
        CMD_FG,
        CMD_FQ,
        CMD_GB,
        CMD_GC,
        CMD_GD,
        CMD_GH,
        CMD_GI,
        CMD_GN,
        CMD_GP,
        CMD_GT,
        CMD_GV,
        CMD_SC,
        CMD_SD,
        CMD_SF,
        CMD_SH,
        CMD_SN,
        CMD_SP
    } t_cmd_code;

    // configuration register indexes
    localparam logic REG_START_CHAR = 1'b0;
    localparam logic REG_END_CHAR   = 1'b1;

    localparam logic [7:0] START_CHAR_RST = 8'd58;
    localparam logic [7:0] END_CHAR_RST   = 8'd35;
    localparam logic [7:0] CHAR_TWO       = 8'h32;

    // first six bytes of the buffer as seen by the decoder, after one
    // leading '2' has been dropped; bytes past the length read as zero
    typedef struct packed {
        logic [5:0][7:0] bytes;
        logic            len_ge1;
        logic            len_ge2;
        logic            len_ge4;
        logic            len_ge6;
    } t_window;

    typedef struct packed {
        logic       clear;
        logic       append;
        logic       decode;
        logic [7:0] data;
    } t_buf_op;

    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c inside {[8'h30:8'h39]}) begin
            d = c - 8'h30;
        end else if (c inside {[8'h41:8'h46]}) begin
            d = c - 8'h37;
        end else if (c inside {[8'h61:8'h66]}) begin
            d = c - 8'h57;
        end
        return d[3:0];
    endfunction

endpackage

### rtl/focuser_command_parser_top.sv
// Serial focuser command parser. One received byte is taken per beat and a
// new byte may follow in every cycle while o_rx_stall is low; each byte passes
// the input register before the command buffer and the result register are
// updated, and a decoded command enters the result register as its end byte
// leaves the input register. The start byte clears the buffer, the end byte
// yields one beat of command_code/command_value, any other byte is stored
// (dropped once the buffer holds BUFFER_DEPTH bytes). o_rx_stall rises only
// when an end byte waits behind a result that the downstream side is still
// stalling. start_char (byte 0x0) and end_char (byte 0x4) are written over the
// APB port by the user only while no byte is in flight; the block does not enforce it.
module focuser_command_parser_top #(
    parameter int BUFFER_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_cmd_valid,
    input  logic        i_cmd_stall,
    output logic [4:0]  o_command_code,
    output logic [15:0] o_command_value
);
    import fcp_pkg::*;

    logic        r_s1_valid;
    logic [7:0]  r_s1_byte;
    logic        r_out_valid;
    logic [4:0]  r_code;
    logic [15:0] r_value;

    logic [7:0]  start_char;
    logic [7:0]  end_char;
    logic        is_start;
    logic        is_end;
    logic        out_free;
    logic        s1_fire;
    logic        rx_accept;
    t_buf_op     buf_op;
    t_window     window;
    t_cmd_code   dec_code;
    logic [15:0] dec_value;

    fcp_apb_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_start_char (start_char),
        .o_end_char   (end_char)
    );

    // start wins when both registers hold the same byte
    assign is_start  = (r_s1_byte == start_char);
    assign is_end    = !is_start && (r_s1_byte == end_char);
    assign out_free  = !r_out_valid || !i_cmd_stall;
    assign s1_fire   = r_s1_valid && (!is_end || out_free);
    assign o_rx_stall = r_s1_valid && !s1_fire;
    assign rx_accept = i_rx_valid && !o_rx_stall;

    always_comb begin
        buf_op.clear  = s1_fire && is_start;
        buf_op.decode = s1_fire && is_end;
        buf_op.append = s1_fire && !is_start && !is_end;
        buf_op.data   = r_s1_byte;
    end

    fcp_cmd_buf #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (buf_op),
        .o_window (window)
    );

    fcp_decode u_dec (
        .i_window (window),
        .o_code   (dec_code),
        .o_value  (dec_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (rx_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_accept) begin
            r_s1_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (buf_op.decode) begin
            r_out_valid <= 1'b1;
        end else if (!i_cmd_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (buf_op.decode) begin
            r_code  <= dec_code;
            r_value <= dec_value;
        end
    end

    assign o_cmd_valid     = r_out_valid;
    assign o_command_code  = r_code;
    assign o_command_value = r_value;

endmodule

### rtl/fcp_apb_regs.sv
module fcp_apb_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  o_start_char,
    output logic [7:0]  o_end_char
);
    import fcp_pkg::*;

    logic [7:0] r_start_char;
    logic [7:0] r_end_char;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_char <= START_CHAR_RST;
            r_end_char   <= END_CHAR_RST;
        end else if (wr_en) begin
            if (paddr[2] == REG_START_CHAR) begin
                r_start_char <= pwdata[7:0];
            end else begin
                r_end_char <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[1:0] == 2'b00) begin
            prdata = (paddr[2] == REG_START_CHAR) ? {24'd0, r_start_char}
                                                  : {24'd0, r_end_char};
        end
    end

    assign o_start_char = r_start_char;
    assign o_end_char   = r_end_char;

endmodule

### rtl/fcp_cmd_buf.sv
module fcp_cmd_buf #(
    parameter int BUFFER_DEPTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fcp_pkg::t_buf_op i_op,
    output fcp_pkg::t_window o_window
);
    import fcp_pkg::*;

    localparam int LW = $clog2(BUFFER_DEPTH + 1);

    logic [7:0]    r_buf [BUFFER_DEPTH];
    logic [LW-1:0] r_len;
    logic [7:0]    vis   [7];
    logic          shift;
    logic [LW-1:0] eff_len;

    // entries at or past the length always read as zero, so clearing only
    // needs the length reset
    always_comb begin
        for (int j = 0; j < 7; j++) begin
            vis[j] = (LW'(j) < r_len) ? r_buf[j] : 8'd0;
        end
    end

    assign shift   = (r_len != '0) && (vis[0] == CHAR_TWO);
    assign eff_len = r_len - LW'(shift);

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            o_window.bytes[k] = shift ? vis[k+1] : vis[k];
        end
        o_window.len_ge1 = eff_len >= LW'(1);
        o_window.len_ge2 = eff_len >= LW'(2);
        o_window.len_ge4 = eff_len >= LW'(4);
        o_window.len_ge6 = eff_len >= LW'(6);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_op.clear) begin
            r_len <= '0;
        end else if (i_op.decode) begin
            r_len <= eff_len;
        end else if (i_op.append && (r_len < LW'(BUFFER_DEPTH))) begin
            r_len <= r_len + LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.decode && shift) begin
            for (int i = 0; i < BUFFER_DEPTH - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
        end else if (i_op.append) begin
            // a full buffer matches no slot, so the byte is dropped
            for (int i = 0; i < BUFFER_DEPTH; i++) begin
                if (r_len == LW'(i)) begin
                    r_buf[i] <= i_op.data;
                end
            end
        end
    end

endmodule

### rtl/fcp_decode.sv
module fcp_decode (
    input  fcp_pkg::t_window   i_window,
    output fcp_pkg::t_cmd_code o_code,
    output logic [15:0]        o_value
);
    import fcp_pkg::*;

    always_comb begin
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] c;
        logic [2:0] ndig;
        logic       stop;

        b0      = i_window.bytes[0];
        b1      = i_window.bytes[1];
        c       = 8'd0;
        ndig    = 3'd0;
        stop    = 1'b0;
        o_code  = CMD_UNKNOWN;
        o_value = 16'd0;

        if (i_window.len_ge1) begin
            if (b0 == "C") begin
                o_code = CMD_C;
            end else if (i_window.len_ge2) begin
                case (b0)
                    "F": begin
                        case (b1)
                            "G":     o_code = CMD_FG;
                            "Q":     o_code = CMD_FQ;
                            default: o_code = CMD_UNKNOWN;
                        endcase
                    end
                    "G": begin
                        case (b1)
                            "B":     o_code = CMD_GB;
                            "C":     o_code = CMD_GC;
                            "D":     o_code = CMD_GD;
                            "H":     o_code = CMD_GH;
                            "I":     o_code = CMD_GI;
                            "N":     o_code = CMD_GN;
                            "P":     o_code = CMD_GP;
                            "T":     o_code = CMD_GT;
                            "V":     o_code = CMD_GV;
                            default: o_code = CMD_UNKNOWN;
                        endcase
                    end
                    "S": begin
                        case (b1)
                            "C": begin
                                if (i_window.len_ge4) begin
                                    o_code = CMD_SC;
                                    ndig   = 3'd2;
                                end
                            end
                            "D": begin
                                if (i_window.len_ge4) begin
                                    o_code = CMD_SD;
                                    ndig   = 3'd2;
                                end
                            end
                            "F":     o_code = CMD_SF;
                            "H":     o_code = CMD_SH;
                            "N": begin
                                if (i_window.len_ge6) begin
                                    o_code = CMD_SN;
                                    ndig   = 3'd4;
                                end
                            end
                            "P": begin
                                if (i_window.len_ge6) begin
                                    o_code = CMD_SP;
                                    ndig   = 3'd4;
                                end
                            end
                            default: o_code = CMD_UNKNOWN;
                        endcase
                    end
                    default: o_code = CMD_UNKNOWN;
                endcase
            end
        end

        // a zero byte ends the digits early
        for (int i = 0; i < 4; i++) begin
            if ((3'(i) < ndig) && !stop) begin
                c = i_window.bytes[2+i];
                if (c == 8'd0) begin
                    stop = 1'b1;
                end else begin
                    o_value = {o_value[11:0], hex_digit(c)};
                end
            end
        end
    end

endmodule

### rtl/fcp_checker.sv
module fcp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_rx_valid,
    input logic        o_rx_stall,
    input logic [7:0]  i_rx_byte,
    input logic        o_cmd_valid,
    input logic        i_cmd_stall,
    input logic [4:0]  o_command_code,
    input logic [15:0] o_command_value
);
    import fcp_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_valid && i_cmd_stall) |=> (o_cmd_valid
            && $stable(o_command_code) && $stable(o_command_value)))
        else $error("result beat changed while stalled");

    a_rx_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rx_valid && o_rx_stall) |=> (i_rx_valid && $stable(i_rx_byte)))
        else $error("byte beat changed while stalled");

    // the byte side only backs up behind a held result
    a_rx_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |-> (o_cmd_valid && i_cmd_stall))
        else $error("byte stall without a stalled result");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_valid |-> (o_command_code <= 5'(CMD_SP)))
        else $error("command code out of range");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_valid && (o_command_code != 5'(CMD_SC))
            && (o_command_code != 5'(CMD_SD))
            && (o_command_code != 5'(CMD_SN))
            && (o_command_code != 5'(CMD_SP))) |-> (o_command_value == 16'd0))
        else $error("argument on a command that takes none");

endmodule

bind focuser_command_parser_top fcp_checker u_fcp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_rx_valid      (i_rx_valid),
    .o_rx_stall      (o_rx_stall),
    .i_rx_byte       (i_rx_byte),
    .o_cmd_valid     (o_cmd_valid),
    .i_cmd_stall     (i_cmd_stall),
    .o_command_code  (o_command_code),
    .o_command_value (o_command_value)
);

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import fcp_pkg::*;

    localparam int          DEPTH       = 8;
    localparam int          QUIET_LIMIT = 2000;
    localparam int          MAX_REPORTS = 20;
    localparam logic [2:0]  ADDR_START  = {REG_START_CHAR, 2'b00};
    localparam logic [2:0]  ADDR_END    = {REG_END_CHAR, 2'b00};

    typedef struct {
        t_cmd_code   code;
        logic [15:0] value;
    } t_cmd_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_rx_valid = 1'b0;
    logic        o_rx_stall;
    logic [7:0]  i_rx_byte = '0;
    logic        o_cmd_valid;
    logic        i_cmd_stall = 1'b0;
    logic [4:0]  o_command_code;
    logic [15:0] o_command_value;

    // parser state as predicted
    logic [7:0]  start_q = START_CHAR_RST;
    logic [7:0]  end_q   = END_CHAR_RST;
    logic [7:0]  cmd_bytes [DEPTH];
    int          cmd_len = 0;
    t_cmd_beat   expected_cmds [$];

    bit          gaps_on = 1'b1;
    int          errors = 0;
    int          bytes_sent = 0;
    int          cmds_checked = 0;
    int          char_settings = 0;
    int          quiet_cycles = 0;
    int          stall_left = 0;
    logic [18:0] codes_seen = '0;

    string       cmd_names [18] = '{"C", "FG", "FQ", "GB", "GC", "GD", "GH", "GI", "GN",
                                    "GP", "GT", "GV", "SC", "SD", "SF", "SH", "SN", "SP"};
    string       hex_chars = "0123456789ABCDEFabcdef";

    focuser_command_parser_top #(.BUFFER_DEPTH(DEPTH)) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_rx_valid      (i_rx_valid),
        .o_rx_stall      (o_rx_stall),
        .i_rx_byte       (i_rx_byte),
        .o_cmd_valid     (o_cmd_valid),
        .i_cmd_stall     (i_cmd_stall),
        .o_command_code  (o_command_code),
        .o_command_value (o_command_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("tb: mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
        end
    endtask

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [3:0] n;
        n = 4'd0;
        if (c >= "0" && c <= "9") begin
            n = 4'(c - "0");
        end else if (c >= "A" && c <= "F") begin
            n = 4'(c - "A" + 10);
        end else if (c >= "a" && c <= "f") begin
            n = 4'(c - "a" + 10);
        end
        return n;
    endfunction

    // the '2' drop below rewrites the buffer for good
    function automatic t_cmd_beat decode_cmd_buffer();
        t_cmd_beat  r;
        logic [7:0] b0;
        logic [7:0] b1;
        int         n_digits;
        bit         stop;
        r.code = CMD_UNKNOWN;
        r.value = '0;
        n_digits = 0;
        stop = 1'b0;
        if (cmd_len > 0 && cmd_bytes[0] == CHAR_TWO) begin
            for (int i = 0; i < DEPTH - 1; i++) cmd_bytes[i] = cmd_bytes[i + 1];
            cmd_bytes[DEPTH - 1] = 8'h00;
            cmd_len--;
        end
        b0 = cmd_bytes[0];
        b1 = cmd_bytes[1];
        if (cmd_len >= 1 && b0 == "C") begin
            r.code = CMD_C;
        end else if (cmd_len >= 2) begin
            case (b0)
                "F": begin
                    if (b1 == "G") r.code = CMD_FG;
                    else if (b1 == "Q") r.code = CMD_FQ;
                end
                "G": begin
                    case (b1)
                        "B": r.code = CMD_GB;
                        "C": r.code = CMD_GC;
                        "D": r.code = CMD_GD;
                        "H": r.code = CMD_GH;
                        "I": r.code = CMD_GI;
                        "N": r.code = CMD_GN;
                        "P": r.code = CMD_GP;
                        "T": r.code = CMD_GT;
                        "V": r.code = CMD_GV;
                        default: ;
                    endcase
                end
                "S": begin
                    case (b1)
                        "C": if (cmd_len >= 4) begin r.code = CMD_SC; n_digits = 2; end
                        "D": if (cmd_len >= 4) begin r.code = CMD_SD; n_digits = 2; end
                        "F": r.code = CMD_SF;
                        "H": r.code = CMD_SH;
                        "N": if (cmd_len >= 6) begin r.code = CMD_SN; n_digits = 4; end
                        "P": if (cmd_len >= 6) begin r.code = CMD_SP; n_digits = 4; end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
        // a zero byte cuts the digits short
        for (int i = 0; i < n_digits; i++) begin
            if (2 + i >= DEPTH || cmd_bytes[2 + i] == 8'h00) stop = 1'b1;
            if (!stop) r.value = {r.value[11:0], nibble_of(cmd_bytes[2 + i])};
        end
        return r;
    endfunction

    function automatic void predict_rx_byte(input logic [7:0] b);
        if (b == start_q) begin
            foreach (cmd_bytes[i]) cmd_bytes[i] = 8'h00;
            cmd_len = 0;
        end else if (b == end_q) begin
            expected_cmds.push_back(decode_cmd_buffer());
        end else if (cmd_len < DEPTH) begin
            cmd_bytes[cmd_len] = b;
            cmd_len++;
        end
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            i_rx_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_rx_stall) @(posedge i_clk);
        predict_rx_byte(b);
        bytes_sent++;
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // sender holds off until every command beat is back, plus pipeline slack
    task automatic drain_cmds();
        i_rx_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_cmds.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_chars(input logic [7:0] start_c, input logic [7:0] end_c);
        logic [31:0] rd;
        drain_cmds();
        apb_write(ADDR_START, {24'd0, start_c});
        apb_write(ADDR_END, {24'd0, end_c});
        start_q = start_c;
        end_q   = end_c;
        char_settings++;
        apb_read(ADDR_START, rd);
        if (rd[7:0] !== start_c) report_mismatch("start_char readback", rd, 32'(start_c));
        apb_read(ADDR_END, rd);
        if (rd[7:0] !== end_c) report_mismatch("end_char readback", rd, 32'(end_c));
    endtask

    task automatic test_reset_values();
        logic [31:0] rd;
        apb_read(ADDR_START, rd);
        if (rd[7:0] !== START_CHAR_RST) begin
            report_mismatch("start_char reset", rd, 32'(START_CHAR_RST));
        end
        apb_read(ADDR_END, rd);
        if (rd[7:0] !== END_CHAR_RST) begin
            report_mismatch("end_char reset", rd, 32'(END_CHAR_RST));
        end
    endtask

    task automatic test_every_command();
        send_string(":C#:FG#:FQ#:GB#:GC#:GD#:GH#:GI#:GN#:GP#:GT#:GV#");
        send_string(":SC7e#:SDF0#:SF#:SH#:SN09aF#:SPfFe1#:XY#:FZ#:GZ#:SZ#");
    endtask

    task automatic test_special_cases();
        send_string(":SN12345678901#");  // overflow bytes dropped
        send_string(":22GP##");          // one '2' per decode, kept dropped
        send_string(":2#:#:2C#");
        send_string(":SC1#:SN123#:G#");  // too short
        send_string(":SPz1q2#");         // non-hex reads as zero
        send_string(":SN1");
        send_byte(8'h00);
        send_string("F#:SC");
        send_byte(8'h00);
        send_string("5#");
    endtask

    task automatic test_start_equals_end();
        set_chars("*", "*");
        send_string(":#GP*SH**");
        set_chars(START_CHAR_RST, END_CHAR_RST);
        send_string("#:#");
    endtask

    task automatic test_char_extremes();
        set_chars(8'h00, 8'hFF);
        send_byte(8'h00);
        send_string("GV");
        send_byte(8'hFF);
        send_byte(8'h00);
        send_string("2SD3c");
        send_byte(8'hFF);
        set_chars(8'hFF, 8'h00);
        send_byte(8'hFF);
        send_string("SP1234");
        send_byte(8'h00);
        send_byte(8'h00);
    endtask

    // mostly framed commands with random content, some noise and broken frames
    task automatic send_random_command();
        logic [7:0] seq [$];
        int         k;
        int         n;
        int         pick;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4)) seq.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) != 0) seq.push_back(start_q);
        if ($urandom_range(0, 5) == 0) begin
            seq.push_back(CHAR_TWO);
            if ($urandom_range(0, 3) == 0) seq.push_back(CHAR_TWO);
        end
        k = $urandom_range(0, 18);
        if (k == 0) begin
            repeat ($urandom_range(1, 2)) seq.push_back(8'($urandom_range("A", "Z")));
        end else begin
            for (int i = 0; i < cmd_names[k - 1].len(); i++) seq.push_back(cmd_names[k - 1][i]);
        end
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : ((k >= 13) ? 4 : 0);
        repeat (n) begin
            pick = $urandom_range(0, 9);
            if (pick < 8) seq.push_back(hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
            else if (pick == 8) seq.push_back(8'($urandom_range(0, 255)));
            else seq.push_back(8'h00);
        end
        pick = $urandom_range(0, 19);
        if (pick != 0) seq.push_back(end_q);
        if (pick == 1) seq.push_back(end_q);
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    task automatic test_random_traffic();
        int budget;
        set_chars(START_CHAR_RST, END_CHAR_RST);
        budget = bytes_sent + 150;
        while (bytes_sent < budget) begin
            send_random_command();
            if (bytes_sent >= budget - 75 && bytes_sent < budget - 65) drain_cmds();
        end
        repeat (4) begin
            set_chars(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            budget = bytes_sent + 40;
            while (bytes_sent < budget) send_random_command();
        end
        set_chars(START_CHAR_RST, END_CHAR_RST);
        gaps_on = 1'b0;
        budget = bytes_sent + 100;
        while (bytes_sent < budget) send_random_command();
    endtask

    // result side: check beats, random stall bursts, watchdog
    always @(posedge i_clk) begin
        t_cmd_beat want;
        if (i_rst_n) begin
            if (o_cmd_valid && !i_cmd_stall) begin
                cmds_checked++;
                if (expected_cmds.size() == 0) begin
                    report_mismatch("unexpected command beat", 32'(o_command_code), 32'd0);
                end else begin
                    want = expected_cmds.pop_front();
                    codes_seen[want.code] = 1'b1;
                    if (o_command_code !== want.code) begin
                        report_mismatch("command_code", 32'(o_command_code), 32'(want.code));
                    end
                    if (o_command_value !== want.value) begin
                        report_mismatch("command_value", 32'(o_command_value),
                                        32'(want.value));
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_cmd_stall <= 1'b1;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 5);
                i_cmd_stall <= 1'b1;
            end else begin
                i_cmd_stall <= 1'b0;
            end
            if ((o_cmd_valid && !i_cmd_stall) || (i_rx_valid && !o_rx_stall)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: timeout, %0d command beats still outstanding",
                         expected_cmds.size());
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        foreach (cmd_bytes[i]) cmd_bytes[i] = 8'h00;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_every_command();
        test_special_cases();
        test_start_equals_end();
        test_char_extremes();
        test_random_traffic();
        drain_cmds();
        $display("tb: %0d bytes sent, %0d command beats checked, %0d character settings",
                 bytes_sent, cmds_checked, char_settings);
        $display("tb: %0d of 19 command codes seen, %0d mismatches",
                 $countones(codes_seen), errors);
        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/fcp_pkg.sv
rtl/fcp_apb_regs.sv
rtl/fcp_cmd_buf.sv
rtl/fcp_decode.sv
rtl/focuser_command_parser_top.sv
rtl/fcp_checker.sv
dv/tb.sv
